// ===== rtl/rfvr_pkg.sv =====
package rfvr_pkg;

   typedef logic signed [31:0] fix_type;
   typedef logic signed [32:0] ext_type;
   typedef logic signed [63:0] wide_type;

   localparam int QX = 0;
   localparam int QY = 1;
   localparam int QZ = 2;
   localparam int QW = 3;

   localparam wide_type HALF_BIAS = 64'sh0000_0000_0800_0000;
   localparam wide_type ONE_Q58   = 64'sh0400_0000_0000_0000;
   localparam wide_type FIX_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam wide_type FIX_MIN   = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic            mode;
      fix_type [3:0]   cur;
      fix_type [3:0]   rest;
      fix_type [2:0]   vec;
   } req_item_type;

   typedef struct packed {
      logic            mode;
      fix_type [3:0]   q;
      fix_type [2:0]   vec;
   } q_item_type;

   typedef struct packed {
      logic                 mode;
      fix_type [2:0][2:0]   m;
      fix_type [2:0]        vec;
   } m_item_type;

   typedef struct packed {
      fix_type [2:0]   res;
   } rsp_item_type;

   function automatic ext_type ext33(input fix_type a);
      ext33 = {a[31], a};
   endfunction

   function automatic ext_type neg33(input fix_type a);
      ext_type e;
      e = {a[31], a};
      neg33 = -e;
   endfunction

   // exact product, floored by 2 bits
   function automatic wide_type mul_fl(input ext_type a, input fix_type b);
      logic signed [64:0] p;
      logic signed [64:0] s;
      p = 65'(a) * 65'(b);
      s = p >>> 2;
      mul_fl = s[63:0];
   endfunction

   // round half up by 28 bits, saturate to 32 bits
   function automatic fix_type round_sat(input wide_type v);
      wide_type t;
      t = (v + HALF_BIAS) >>> 28;
      if (t > FIX_MAX) begin
         round_sat = FIX_MAX[31:0];
      end else if (t < FIX_MIN) begin
         round_sat = FIX_MIN[31:0];
      end else begin
         round_sat = t[31:0];
      end
   endfunction

endpackage

// ===== rtl/rfvr_ifs.sv =====
interface rfvr_req_if;
   import rfvr_pkg::*;
   logic    valid;
   logic    ready;
   logic    mode;
   fix_type cur_qx;
   fix_type cur_qy;
   fix_type cur_qz;
   fix_type cur_qw;
   fix_type rest_qx;
   fix_type rest_qy;
   fix_type rest_qz;
   fix_type rest_qw;
   fix_type vec_x;
   fix_type vec_y;
   fix_type vec_z;
   modport source (output valid, mode, cur_qx, cur_qy, cur_qz, cur_qw,
                   rest_qx, rest_qy, rest_qz, rest_qw, vec_x, vec_y, vec_z,
                   input ready);
   modport sink (input valid, mode, cur_qx, cur_qy, cur_qz, cur_qw,
                 rest_qx, rest_qy, rest_qz, rest_qw, vec_x, vec_y, vec_z,
                 output ready);
endinterface

interface rfvr_rsp_if;
   import rfvr_pkg::*;
   logic    valid;
   logic    ready;
   fix_type out_x;
   fix_type out_y;
   fix_type out_z;
   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface rfvr_csr_if;
   logic valid;
   logic ready;
   logic use_relative_rotation;
   modport source (output valid, use_relative_rotation, input ready);
   modport sink (input valid, use_relative_rotation, output ready);
endinterface

// ===== rtl/rigid_frame_vector_rotator_core.sv =====
// Rotates a Q16.16 3-vector by a frame quaternion (Q2.30).
// req_if: one item = mode, current and rest orientation quaternions, vector.
//   The frame rotation is cur * conj(rest), or cur alone when the
//   use_relative_rotation register is clear. Mode 1 rotates forward, mode 0
//   applies the inverse rotation.
// rsp_if: one item per request, out_x/out_y/out_z, saturated Q16.16.
// csr_if: writes use_relative_rotation; always ready. Write it only while
//   no item is in flight.
// Pipeline: six registers in three multiply/sum stage pairs (quaternion product,
//   rotation matrix, matrix times vector).
// Throughput: one item per cycle while rsp_if.ready is high. Every stage has
//   its own valid bit and loads when empty or when the stage after it moves,
//   so bubbles close up.
// Receiver stall: the output register holds its item; items keep entering
//   until all six stages are full, then req_if.ready drops. Nothing is lost.
// Reset: all stages empty, use_relative_rotation set to 1.
module rigid_frame_vector_rotator_core (
   input  logic        clock,
   input  logic        reset,
   rfvr_csr_if.sink    csr_if,
   rfvr_req_if.sink    req_if,
   rfvr_rsp_if.source  rsp_if
);
   import rfvr_pkg::*;

   logic           use_rel_ff;
   req_item_type   req_data;
   logic           q_valid;
   logic           q_ready;
   q_item_type     q_data;
   logic           m_valid;
   logic           m_ready;
   m_item_type     m_data;
   rsp_item_type   rsp_data;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_rel_ff <= 1'b1;
      end else if (csr_if.valid) begin
         use_rel_ff <= csr_if.use_relative_rotation;
      end
   end

   assign req_data.mode     = req_if.mode;
   assign req_data.cur[QX]  = req_if.cur_qx;
   assign req_data.cur[QY]  = req_if.cur_qy;
   assign req_data.cur[QZ]  = req_if.cur_qz;
   assign req_data.cur[QW]  = req_if.cur_qw;
   assign req_data.rest[QX] = req_if.rest_qx;
   assign req_data.rest[QY] = req_if.rest_qy;
   assign req_data.rest[QZ] = req_if.rest_qz;
   assign req_data.rest[QW] = req_if.rest_qw;
   assign req_data.vec[0]   = req_if.vec_x;
   assign req_data.vec[1]   = req_if.vec_y;
   assign req_data.vec[2]   = req_if.vec_z;

   rfvr_qprod u_qprod (
      .clock     (clock),
      .reset     (reset),
      .use_rel   (use_rel_ff),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   rfvr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_data  (m_data)
   );

   rfvr_matvec u_matvec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_data   (m_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.out_x = rsp_data.res[0];
   assign rsp_if.out_y = rsp_data.res[1];
   assign rsp_if.out_z = rsp_data.res[2];

endmodule

// ===== rtl/rfvr_qprod.sv =====
module rfvr_qprod (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   use_rel,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rfvr_pkg::req_item_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rfvr_pkg::q_item_type   out_data
);
   import rfvr_pkg::*;

   logic         s1_valid_ff;
   logic         s1_mode_ff;
   fix_type      s1_cur_ff [4];
   fix_type      s1_vec_ff [3];
   wide_type     prod_ff [16];
   wide_type     prod_in [16];
   logic         s2_valid_ff;
   q_item_type   s2_data_ff;
   q_item_type   s2_data_in;
   logic         s1_load;
   logic         s2_load;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   always_comb begin
      fix_type cx, cy, cz, cw;
      ext_type bx, by, bz, bw;
      cx = in_data.cur[QX];
      cy = in_data.cur[QY];
      cz = in_data.cur[QZ];
      cw = in_data.cur[QW];
      bx = neg33(in_data.rest[QX]);
      by = neg33(in_data.rest[QY]);
      bz = neg33(in_data.rest[QZ]);
      bw = ext33(in_data.rest[QW]);
      prod_in[0]  = mul_fl(bw, cw);
      prod_in[1]  = mul_fl(bx, cx);
      prod_in[2]  = mul_fl(by, cy);
      prod_in[3]  = mul_fl(bz, cz);
      prod_in[4]  = mul_fl(bx, cw);
      prod_in[5]  = mul_fl(bw, cx);
      prod_in[6]  = mul_fl(bz, cy);
      prod_in[7]  = mul_fl(by, cz);
      prod_in[8]  = mul_fl(by, cw);
      prod_in[9]  = mul_fl(bz, cx);
      prod_in[10] = mul_fl(bw, cy);
      prod_in[11] = mul_fl(bx, cz);
      prod_in[12] = mul_fl(bz, cw);
      prod_in[13] = mul_fl(by, cx);
      prod_in[14] = mul_fl(bx, cy);
      prod_in[15] = mul_fl(bw, cz);
   end

   always_comb begin
      wide_type sw, sx, sy, sz;
      sw = prod_ff[0] - prod_ff[1] - prod_ff[2] - prod_ff[3];
      sx = prod_ff[4] + prod_ff[5] + prod_ff[6] - prod_ff[7];
      sy = prod_ff[8] - prod_ff[9] + prod_ff[10] + prod_ff[11];
      sz = prod_ff[12] + prod_ff[13] - prod_ff[14] + prod_ff[15];
      s2_data_in.mode = s1_mode_ff;
      for (int i = 0; i < 3; i++) begin
         s2_data_in.vec[i] = s1_vec_ff[i];
      end
      if (use_rel) begin
         s2_data_in.q[QX] = round_sat(sx);
         s2_data_in.q[QY] = round_sat(sy);
         s2_data_in.q[QZ] = round_sat(sz);
         s2_data_in.q[QW] = round_sat(sw);
      end else begin
         for (int i = 0; i < 4; i++) begin
            s2_data_in.q[i] = s1_cur_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_mode_ff <= in_data.mode;
         for (int i = 0; i < 4; i++) begin
            s1_cur_ff[i] <= in_data.cur[i];
         end
         for (int i = 0; i < 3; i++) begin
            s1_vec_ff[i] <= in_data.vec[i];
         end
         for (int i = 0; i < 16; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (s2_load) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/rfvr_matrix.sv =====
module rfvr_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rfvr_pkg::q_item_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfvr_pkg::m_item_type out_data
);
   import rfvr_pkg::*;

   logic         s1_valid_ff;
   logic         s1_mode_ff;
   fix_type      s1_vec_ff [3];
   wide_type     prod_ff [9];
   wide_type     prod_in [9];
   logic         s2_valid_ff;
   m_item_type   s2_data_ff;
   m_item_type   s2_data_in;
   logic         s1_load;
   logic         s2_load;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   // order: xx yy zz xy xz yz xw yw zw
   always_comb begin
      fix_type x, y, z, w;
      x = in_data.q[QX];
      y = in_data.q[QY];
      z = in_data.q[QZ];
      w = in_data.q[QW];
      prod_in[0] = mul_fl(ext33(x), x);
      prod_in[1] = mul_fl(ext33(y), y);
      prod_in[2] = mul_fl(ext33(z), z);
      prod_in[3] = mul_fl(ext33(x), y);
      prod_in[4] = mul_fl(ext33(x), z);
      prod_in[5] = mul_fl(ext33(y), z);
      prod_in[6] = mul_fl(ext33(x), w);
      prod_in[7] = mul_fl(ext33(y), w);
      prod_in[8] = mul_fl(ext33(z), w);
   end

   always_comb begin
      wide_type xx, yy, zz, xy, xz, yz, xw, yw, zw;
      xx = prod_ff[0];
      yy = prod_ff[1];
      zz = prod_ff[2];
      xy = prod_ff[3];
      xz = prod_ff[4];
      yz = prod_ff[5];
      xw = prod_ff[6];
      yw = prod_ff[7];
      zw = prod_ff[8];
      s2_data_in.mode    = s1_mode_ff;
      for (int i = 0; i < 3; i++) begin
         s2_data_in.vec[i] = s1_vec_ff[i];
      end
      s2_data_in.m[0][0] = round_sat(ONE_Q58 - ((yy + zz) <<< 1));
      s2_data_in.m[0][1] = round_sat((xy - zw) <<< 1);
      s2_data_in.m[0][2] = round_sat((xz + yw) <<< 1);
      s2_data_in.m[1][0] = round_sat((xy + zw) <<< 1);
      s2_data_in.m[1][1] = round_sat(ONE_Q58 - ((xx + zz) <<< 1));
      s2_data_in.m[1][2] = round_sat((yz - xw) <<< 1);
      s2_data_in.m[2][0] = round_sat((xz - yw) <<< 1);
      s2_data_in.m[2][1] = round_sat((yz + xw) <<< 1);
      s2_data_in.m[2][2] = round_sat(ONE_Q58 - ((xx + yy) <<< 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_mode_ff <= in_data.mode;
         for (int i = 0; i < 3; i++) begin
            s1_vec_ff[i] <= in_data.vec[i];
         end
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (s2_load) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/rfvr_matvec.sv =====
module rfvr_matvec (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rfvr_pkg::m_item_type   in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rfvr_pkg::rsp_item_type out_data
);
   import rfvr_pkg::*;

   logic           s1_valid_ff;
   wide_type       prod_ff [9];
   wide_type       prod_in [9];
   logic           s2_valid_ff;
   rsp_item_type   s2_data_ff;
   rsp_item_type   s2_data_in;
   logic           s1_load;
   logic           s2_load;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   // mode 1: R*v, mode 0: R^T*v
   always_comb begin
      fix_type e;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            e = in_data.mode ? in_data.m[i][j] : in_data.m[j][i];
            prod_in[3*i+j] = mul_fl(ext33(e), in_data.vec[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_data_in.res[i] = round_sat(prod_ff[3*i] + prod_ff[3*i+1] + prod_ff[3*i+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (s2_load) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/rfvr_checker.sv =====
module rfvr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_x,
   input logic [31:0] rsp_y,
   input logic [31:0] rsp_z
);

   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (in_acc && !out_acc) begin
         cnt_in = cnt_ff + 3'd1;
      end else if (!in_acc && out_acc) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 3'd0)
      else $error("response without an item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd6)
      else $error("more items in flight than pipeline stages");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z))
      else $error("response changed while stalled");

endmodule

bind rigid_frame_vector_rotator_core rfvr_checker u_rfvr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_x     (rsp_if.out_x),
   .rsp_y     (rsp_if.out_y),
   .rsp_z     (rsp_if.out_z)
);

// ===== dv/rigid_frame_vector_rotator_core_tb.sv =====
`timescale 1ns / 100ps

module rigid_frame_vector_rotator_core_tb;
   import rfvr_pkg::*;

   localparam int     PIPE_DEPTH  = 6;
   localparam int     HOLD_CYCLES = 40;
   localparam int     PHASE_ITEMS = 300;
   localparam int     NUM_PHASES  = 6;
   localparam longint LIMIT       = 400000;

   localparam longint FIX_HI = 64'sd2147483647;
   localparam longint FIX_LO = -64'sd2147483648;
   localparam longint ONE_58 = 64'sd1 <<< 58;

   localparam fix_type F_ONE = 32'sh4000_0000;   // 1.0 in Q2.30
   localparam fix_type F_HALF = 32'sh2000_0000;
   localparam fix_type V1 = 32'sh0001_0000;      // 1.0 in Q16.16
   localparam fix_type V2 = 32'sh0002_0000;
   localparam fix_type V3 = 32'sh0003_0000;
   localparam fix_type MAXF = 32'sh7FFF_FFFF;
   localparam fix_type MINF = 32'sh8000_0000;
   localparam fix_type ALT = 32'sh5555_5555;
   localparam fix_type NALT = 32'shAAAA_AAAA;

   typedef struct packed {
      logic              rel;
      logic              known;
      req_item_type      item;
      fix_type [2:0]     want;
   } dir_row_type;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   longint cycles = 0;

   bit     rel_cfg = 1'b1;
   int     req_idle_pct = 20;
   int     rsp_idle_pct = 20;
   int     hold_seq = 0;

   int     items_sent = 0;
   int     results_checked = 0;
   int     cfg_writes = 0;
   int     fails = 0;

   fix_type [2:0] pending_rot [$];
   fix_type [2:0] rsp_seen;
   fix_type [2:0] rsp_want;
   string         axis_name [3] = '{"out_x", "out_y", "out_z"};

   bit ph_rel [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   int ph_req [NUM_PHASES] = '{0, 30, 0, 50, 15, 5};
   int ph_rsp [NUM_PHASES] = '{0, 30, 50, 0, 15, 60};
   bit ph_hold [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

   rfvr_csr_if csr_ch();
   rfvr_req_if req_ch();
   rfvr_rsp_if rsp_ch();

   rigid_frame_vector_rotator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_ch),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("rigid_frame_vector_rotator_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint sx(input fix_type a);
      return longint'(a);
   endfunction

   function automatic longint prod_floor(input longint a, input longint b);
      return (a * b) >>> 2;
   endfunction

   function automatic longint round_clamp(input longint v);
      longint t;
      t = (v + (64'sd1 <<< 27)) >>> 28;
      if (t > FIX_HI) t = FIX_HI;
      if (t < FIX_LO) t = FIX_LO;
      return t;
   endfunction

   function automatic fix_type [2:0] rotate_vec(input req_item_type it, input bit rel);
      longint c [4];
      longint b [4];
      longint q [4];
      longint v [3];
      longint m [3][3];
      longint xx, yy, zz, xy, xz, yz, xw, yw, zw, acc;
      fix_type [2:0] res;
      int i, j;
      for (i = 0; i < 4; i++) c[i] = sx(it.cur[i]);
      for (i = 0; i < 3; i++) v[i] = sx(it.vec[i]);
      if (rel) begin
         b[QX] = -sx(it.rest[QX]);
         b[QY] = -sx(it.rest[QY]);
         b[QZ] = -sx(it.rest[QZ]);
         b[QW] = sx(it.rest[QW]);
         q[QW] = round_clamp(prod_floor(c[QW], b[QW]) - prod_floor(c[QX], b[QX])
                             - prod_floor(c[QY], b[QY]) - prod_floor(c[QZ], b[QZ]));
         q[QX] = round_clamp(prod_floor(c[QW], b[QX]) + prod_floor(c[QX], b[QW])
                             + prod_floor(c[QY], b[QZ]) - prod_floor(c[QZ], b[QY]));
         q[QY] = round_clamp(prod_floor(c[QW], b[QY]) - prod_floor(c[QX], b[QZ])
                             + prod_floor(c[QY], b[QW]) + prod_floor(c[QZ], b[QX]));
         q[QZ] = round_clamp(prod_floor(c[QW], b[QZ]) + prod_floor(c[QX], b[QY])
                             - prod_floor(c[QY], b[QX]) + prod_floor(c[QZ], b[QW]));
      end else begin
         q = c;
      end
      xx = prod_floor(q[QX], q[QX]);
      yy = prod_floor(q[QY], q[QY]);
      zz = prod_floor(q[QZ], q[QZ]);
      xy = prod_floor(q[QX], q[QY]);
      xz = prod_floor(q[QX], q[QZ]);
      yz = prod_floor(q[QY], q[QZ]);
      xw = prod_floor(q[QX], q[QW]);
      yw = prod_floor(q[QY], q[QW]);
      zw = prod_floor(q[QZ], q[QW]);
      m[0][0] = round_clamp(ONE_58 - 2 * (yy + zz));
      m[0][1] = round_clamp(2 * (xy - zw));
      m[0][2] = round_clamp(2 * (xz + yw));
      m[1][0] = round_clamp(2 * (xy + zw));
      m[1][1] = round_clamp(ONE_58 - 2 * (xx + zz));
      m[1][2] = round_clamp(2 * (yz - xw));
      m[2][0] = round_clamp(2 * (xz - yw));
      m[2][1] = round_clamp(2 * (yz + xw));
      m[2][2] = round_clamp(ONE_58 - 2 * (xx + yy));
      for (i = 0; i < 3; i++) begin
         acc = 0;
         for (j = 0; j < 3; j++) begin
            acc += prod_floor(it.mode ? m[i][j] : m[j][i], v[j]);
         end
         res[i] = fix_type'(round_clamp(acc));
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic fix_type [3:0] quat(input fix_type x, y, z, w);
      fix_type [3:0] q;
      q[QX] = x;
      q[QY] = y;
      q[QZ] = z;
      q[QW] = w;
      return q;
   endfunction

   function automatic fix_type [2:0] vec3(input fix_type x, y, z);
      return {z, y, x};
   endfunction

   function automatic dir_row_type stim_row(input int rel, mode, input fix_type [3:0] c, r,
                                            input fix_type [2:0] v, input int known,
                                            input fix_type [2:0] want);
      dir_row_type d;
      d.rel = rel[0];
      d.known = known[0];
      d.item.mode = mode[0];
      d.item.cur = c;
      d.item.rest = r;
      d.item.vec = v;
      d.want = want;
      return d;
   endfunction

   function automatic int idle_len(input int pct);
      int r;
      if ($urandom_range(99) >= pct) return 0;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic fix_type any_fix();
      case ($urandom_range(9))
         0: return MAXF;
         1: return MINF;
         2: return 0;
         default: return fix_type'($urandom);
      endcase
   endfunction

   function automatic fix_type edge_fix();
      case ($urandom_range(6))
         0: return MAXF;
         1: return MINF;
         2: return 0;
         3: return F_ONE;
         4: return -F_ONE;
         5: return -1;
         default: return 1;
      endcase
   endfunction

   // random unit quaternion, no trig needed
   function automatic fix_type [3:0] unit_quat();
      real a [4];
      real n;
      fix_type [3:0] q;
      int k;
      n = 0.0;
      for (k = 0; k < 4; k++) begin
         a[k] = (real'($urandom_range(2000000)) - 1.0e6) / 1.0e6;
         n += a[k] * a[k];
      end
      if (n < 1.0e-6) return quat(0, 0, 0, F_ONE);
      n = $sqrt(n);
      for (k = 0; k < 4; k++) q[k] = fix_type'($rtoi(a[k] / n * 1073741824.0));
      return q;
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      int cls;
      int k;
      cls = $urandom_range(99);
      it.mode = 1'($urandom_range(1));
      if (cls < 70) begin
         it.cur = unit_quat();
         it.rest = ($urandom_range(3) == 0) ? it.cur : unit_quat();
         for (k = 0; k < 3; k++) it.vec[k] = fix_type'($urandom) >>> $urandom_range(20);
      end else if (cls < 90) begin
         for (k = 0; k < 4; k++) begin
            it.cur[k] = any_fix();
            it.rest[k] = any_fix();
         end
         for (k = 0; k < 3; k++) it.vec[k] = any_fix();
      end else begin
         for (k = 0; k < 4; k++) begin
            it.cur[k] = edge_fix();
            it.rest[k] = edge_fix();
         end
         for (k = 0; k < 3; k++) it.vec[k] = edge_fix();
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it, input bit known,
                            input fix_type [2:0] want);
      int gap;
      gap = idle_len(req_idle_pct);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.mode <= it.mode;
      req_ch.cur_qx <= it.cur[QX];
      req_ch.cur_qy <= it.cur[QY];
      req_ch.cur_qz <= it.cur[QZ];
      req_ch.cur_qw <= it.cur[QW];
      req_ch.rest_qx <= it.rest[QX];
      req_ch.rest_qy <= it.rest[QY];
      req_ch.rest_qz <= it.rest[QZ];
      req_ch.rest_qw <= it.rest[QW];
      req_ch.vec_x <= it.vec[0];
      req_ch.vec_y <= it.vec[1];
      req_ch.vec_z <= it.vec[2];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_rot.push_back(known ? want : rotate_vec(it, rel_cfg));
      items_sent++;
   endtask

   // register write only with the pipe drained
   task automatic write_rel(input bit val);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rot.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.use_relative_rotation <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      rel_cfg = val;
      cfg_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- sink side

   initial begin
      int hold_left;
      int stall_left;
      int hold_seen;
      hold_left = 0;
      stall_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = idle_len(rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_seen = {rsp_ch.out_z, rsp_ch.out_y, rsp_ch.out_x};
         if (pending_rot.size() == 0) begin
            $display("%0t: unexpected item out=(%0d, %0d, %0d)", $time,
                     rsp_seen[0], rsp_seen[1], rsp_seen[2]);
            fails++;
         end else begin
            rsp_want = pending_rot.pop_front();
            results_checked++;
            for (int k = 0; k < 3; k++) begin
               if (rsp_seen[k] !== rsp_want[k]) begin
                  $display("%0t: %s expected %0d (0x%08h) actual %0d (0x%08h)", $time,
                           axis_name[k], rsp_want[k], rsp_want[k], rsp_seen[k], rsp_seen[k]);
                  fails++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      dir_row_type dir_rows [$];
      fix_type [3:0] q_id, q_zero, q_rx, q_ry, q_rz, q_half, q_wmin;
      fix_type [3:0] q_max, q_min, q_alt, q_alt2;
      int p;
      int n;

      req_ch.valid <= 1'b0;
      req_ch.mode <= 1'b0;
      req_ch.cur_qx <= '0;
      req_ch.cur_qy <= '0;
      req_ch.cur_qz <= '0;
      req_ch.cur_qw <= '0;
      req_ch.rest_qx <= '0;
      req_ch.rest_qy <= '0;
      req_ch.rest_qz <= '0;
      req_ch.rest_qw <= '0;
      req_ch.vec_x <= '0;
      req_ch.vec_y <= '0;
      req_ch.vec_z <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.use_relative_rotation <= 1'b1;

      q_id = quat(0, 0, 0, F_ONE);
      q_zero = quat(0, 0, 0, 0);
      q_rx = quat(F_ONE, 0, 0, 0);
      q_ry = quat(0, F_ONE, 0, 0);
      q_rz = quat(0, 0, F_ONE, 0);
      q_half = quat(F_HALF, F_HALF, F_HALF, F_HALF);   // 120 deg about (1,1,1)
      q_wmin = quat(0, 0, 0, MINF);
      q_max = quat(MAXF, MAXF, MAXF, MAXF);
      q_min = quat(MINF, MINF, MINF, MINF);
      q_alt = quat(ALT, NALT, ALT, NALT);
      q_alt2 = quat(NALT, ALT, NALT, ALT);

      dir_rows.push_back(stim_row(1, 1, q_id, q_id, vec3(V1, -V2, V3), 1, vec3(V1, -V2, V3)));
      dir_rows.push_back(stim_row(1, 0, q_id, q_id, vec3(MAXF, MINF, 0), 1, vec3(MAXF, MINF, 0)));
      dir_rows.push_back(stim_row(1, 1, q_zero, q_zero, vec3(MAXF, MINF, -1), 1,
                                  vec3(MAXF, MINF, -1)));
      dir_rows.push_back(stim_row(1, 1, q_rz, q_id, vec3(V1, V2, V3), 1, vec3(-V1, -V2, V3)));
      dir_rows.push_back(stim_row(1, 0, q_rz, q_id, vec3(V1, V2, V3), 1, vec3(-V1, -V2, V3)));
      dir_rows.push_back(stim_row(1, 1, q_id, q_rz, vec3(V1, V2, V3), 1, vec3(-V1, -V2, V3)));
      dir_rows.push_back(stim_row(1, 0, q_ry, q_id, vec3(V1, V2, V3), 1, vec3(-V1, V2, -V3)));
      dir_rows.push_back(stim_row(1, 1, q_half, q_id, vec3(V1, V2, V3), 1, vec3(V3, V1, V2)));
      dir_rows.push_back(stim_row(1, 0, q_half, q_id, vec3(V1, V2, V3), 1, vec3(V2, V3, V1)));
      dir_rows.push_back(stim_row(1, 1, q_max, q_max, vec3(MAXF, MAXF, MAXF), 0, '0));
      dir_rows.push_back(stim_row(1, 0, q_min, q_min, vec3(MINF, MINF, MINF), 0, '0));
      dir_rows.push_back(stim_row(1, 1, q_max, q_min, vec3(MAXF, MINF, MAXF), 0, '0));
      dir_rows.push_back(stim_row(1, 0, q_alt, q_alt2, vec3(ALT, NALT, ALT), 0, '0));
      dir_rows.push_back(stim_row(0, 1, q_id, q_max, vec3(MAXF, MINF, V1), 1,
                                  vec3(MAXF, MINF, V1)));
      dir_rows.push_back(stim_row(0, 0, q_rz, q_min, vec3(V1, V2, V3), 1, vec3(-V1, -V2, V3)));
      dir_rows.push_back(stim_row(0, 1, q_wmin, q_id, vec3(MINF, MAXF, -V3), 1,
                                  vec3(MINF, MAXF, -V3)));
      dir_rows.push_back(stim_row(0, 1, q_rx, q_id, vec3(V1, V2, V3), 1, vec3(V1, -V2, -V3)));
      dir_rows.push_back(stim_row(0, 0, q_max, q_id, vec3(MAXF, MAXF, MINF), 0, '0));
      dir_rows.push_back(stim_row(0, 1, q_min, q_max, vec3(MINF, MAXF, MINF), 0, '0));
      dir_rows.push_back(stim_row(0, 1, q_alt, q_id, vec3(NALT, ALT, NALT), 0, '0));
      dir_rows.push_back(stim_row(1, 1, q_id, q_id, vec3(MINF, 0, MAXF), 1, vec3(MINF, 0, MAXF)));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].rel != rel_cfg) write_rel(dir_rows[i].rel);
         send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         if (ph_rel[p] != rel_cfg) write_rel(ph_rel[p]);
         req_idle_pct = ph_req[p];
         rsp_idle_pct = ph_rsp[p];
         if (ph_hold[p]) hold_seq++;   // sink holds off while the source streams
         for (n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, '0);
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rot.size() != 0) @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      $display("%0d items (%0d directed), %0d results checked, %0d register writes",
               items_sent, dir_rows.size(), results_checked, cfg_writes);
      $display("covered relative/absolute frames, both directions, saturation, sink hold-off");
      if (fails == 0) begin
         $display("rigid_frame_vector_rotator_core: match");
      end else begin
         $display("rigid_frame_vector_rotator_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rfvr_pkg.sv
rtl/rfvr_ifs.sv
rtl/rfvr_qprod.sv
rtl/rfvr_matrix.sv
rtl/rfvr_matvec.sv
rtl/rigid_frame_vector_rotator_core.sv
rtl/rfvr_checker.sv
dv/rigid_frame_vector_rotator_core_tb.sv
